// ----- hdl/vsr_pkg.sv -----
// Shared types, constants and helper functions for the sine voice block.
// Depends on nothing; vsr_core and the top level import it.
package vsr_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int SCALE_W    = 36;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 36'd5864062015;

  // tail gain, Q1.16
  localparam logic [16:0] TAIL_ONE   = 17'd65536;
  localparam logic [15:0] TAIL_DECAY = 16'd64881;
  localparam logic [16:0] TAIL_STOP  = 17'd327;

  // amp = (vel * 98304 + 635) / 1270, done as (x * AMP_MAGIC) >> 35, exact for x < 2^24
  localparam logic [31:0] AMP_MAGIC = 32'd27054913;
  localparam logic [23:0] AMP_ROUND = 24'd635;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [46:0] HALF_Q30 = 47'h2000_0000;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_NOTE_ON = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_STOP    = 2'd3
  } vsr_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ON_AMP,
    ST_ON_LO,
    ST_ON_HI,
    ST_ON_FIN,
    ST_TK_SQ,
    ST_TK_T2,
    ST_TK_HM,
    ST_TK_HA,
    ST_TK_S,
    ST_TK_MAG,
    ST_TK_AMP,
    ST_TK_P,
    ST_TK_TL,
    ST_TK_DEC,
    ST_EMIT,
    ST_WB
  } vsr_fsm_t;

  // one voice word as kept in the state memory
  typedef struct packed {
    logic [16:0] tail;
    logic [15:0] amp;
    logic [31:0] step;
    logic [31:0] phase;
  } vsr_state_t;

  typedef struct packed {
    logic               active;
    logic signed [15:0] sample;
  } vsr_res_t;

  // Q16.16 frequencies of MIDI notes 120 to 131
  localparam logic [31:0] TOP_Q16 [12] = '{
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
    32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
  };

  // odd sine polynomial in Q30, lowest order first
  localparam logic [31:0] SIN_COEF [5] = '{
    32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
  };

  // Q16.16 frequency of a MIDI note: top-octave entry shifted down by octave
  function automatic logic [31:0] note_freq(input logic [6:0] note);
    logic [3:0] oct;
    logic [6:0] semi;
    logic [3:0] shamt;
    oct = '0;
    for (int i = 1; i <= 10; i++) begin
      if (note >= 7'(12 * i)) oct = oct + 4'd1;
    end
    semi  = note - ({3'b0, oct} << 3) - ({3'b0, oct} << 2);
    shamt = 4'd10 - oct;
    return TOP_Q16[semi[3:0]] >> shamt;
  endfunction

endpackage

// ----- hdl/vsr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module vsr_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 1,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/vsr_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing.
module vsr_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

  assign prod = prod_r;

endmodule

// ----- hdl/vsr_core.sv -----
// Voice sequencer: loads the voice word, runs note-on and tick through the shared
// multiplier, applies release and stop directly, and writes the word back. Depends on vsr_pkg.
module vsr_core
  import vsr_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  output logic               req_ready,
  input  vsr_req_t           req_type,
  input  logic [6:0]         note_number,
  input  logic [6:0]         note_velocity,
  input  logic [SCALE_W-1:0] scale,
  input  vsr_state_t         mem_rd_data,
  output logic               mem_wr_en,
  output vsr_state_t         mem_wr_data,
  output logic [31:0]        mul_a,
  output logic [31:0]        mul_b,
  input  logic [63:0]        mul_p,
  output logic               res_valid,
  input  logic               res_ready,
  output vsr_res_t           res
);

  // table depth is a power of two: the angle keeps only the top SINE_LOG phase bits
  localparam int SINE_LOG = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - SINE_LOG)) - 32'd1);

  vsr_fsm_t     fsm_r, fsm_nxt;
  logic         mem_ok_r, mem_ok_nxt;
  vsr_req_t     req_r, req_nxt;
  logic [6:0]   note_r, note_nxt;
  logic [6:0]   vel_r, vel_nxt;
  vsr_state_t   st_r, st_nxt;
  logic [30:0]  t_r, t_nxt;
  logic [30:0]  t2_r, t2_nxt;
  logic [31:0]  r_r, r_nxt;
  logic [1:0]   k_r, k_nxt;
  logic         neg_r, neg_nxt;
  logic [14:0]  mag_r, mag_nxt;
  logic signed [15:0] samp_r, samp_nxt;

  vsr_state_t   cur;
  logic [31:0]  ang;
  logic [31:0]  freq;
  logic [23:0]  amp_x;
  logic [31:0]  sine_s;
  logic [46:0]  sine_m;
  logic [16:0]  gain_m;
  logic [15:0]  mag16;
  logic [16:0]  tail_dec;

  function automatic logic [14:0] sat15(input logic [16:0] v);
    return (v > 17'd32767) ? 15'h7fff : v[14:0];
  endfunction

  assign cur    = mem_ok_r ? mem_rd_data : '0;
  assign ang    = cur.phase & ANG_MASK;
  assign freq   = note_freq(note_r);
  assign amp_x  = ({17'b0, vel_r} << 16) + ({17'b0, vel_r} << 15) + AMP_ROUND;
  assign sine_s = mul_p[61:30];
  assign sine_m = {sine_s, 15'b0} - {15'b0, sine_s} + HALF_Q30;

  always_comb begin
    fsm_nxt    = fsm_r;
    mem_ok_nxt = mem_ok_r;
    req_nxt    = req_r;
    note_nxt   = note_r;
    vel_nxt    = vel_r;
    st_nxt     = st_r;
    t_nxt      = t_r;
    t2_nxt     = t2_r;
    r_nxt      = r_r;
    k_nxt      = k_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    samp_nxt   = samp_r;
    mul_a      = '0;
    mul_b      = '0;
    mem_wr_en  = 1'b0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    gain_m     = '0;
    mag16      = '0;
    tail_dec   = mul_p[32:16];

    unique case (fsm_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt  = req_type;
          note_nxt = note_number;
          vel_nxt  = note_velocity;
          fsm_nxt  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        st_nxt  = cur;
        t_nxt   = ang[30] ? (ONE_Q30 - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
        neg_nxt = ang[31];
        unique case (req_r)
          REQ_TICK: begin
            if (cur.step == '0) begin
              samp_nxt = '0;
              fsm_nxt  = ST_EMIT;
            end else begin
              fsm_nxt = ST_TK_SQ;
            end
          end
          REQ_NOTE_ON: fsm_nxt = ST_ON_AMP;
          REQ_RELEASE: begin
            if (cur.tail == '0) st_nxt.tail = TAIL_ONE;
            fsm_nxt = ST_WB;
          end
          REQ_STOP: begin
            st_nxt.step = '0;
            st_nxt.tail = '0;
            fsm_nxt     = ST_WB;
          end
        endcase
      end
      ST_ON_AMP: begin
        mul_a   = {8'b0, amp_x};
        mul_b   = AMP_MAGIC;
        fsm_nxt = ST_ON_LO;
      end
      ST_ON_LO: begin
        st_nxt.amp = mul_p[50:35];
        mul_a      = freq;
        mul_b      = scale[31:0];
        fsm_nxt    = ST_ON_HI;
      end
      ST_ON_HI: begin
        st_nxt.step = mul_p[63:32];
        mul_a       = freq;
        mul_b       = {28'b0, scale[SCALE_W-1:32]};
        fsm_nxt     = ST_ON_FIN;
      end
      ST_ON_FIN: begin
        st_nxt.step  = st_r.step + mul_p[31:0];
        st_nxt.phase = '0;
        st_nxt.tail  = '0;
        fsm_nxt      = ST_WB;
      end
      ST_TK_SQ: begin
        mul_a        = {1'b0, t_r};
        mul_b        = {1'b0, t_r};
        st_nxt.phase = st_r.phase + st_r.step;
        fsm_nxt      = ST_TK_T2;
      end
      ST_TK_T2: begin
        t2_nxt  = mul_p[60:30];
        r_nxt   = SIN_COEF[4];
        k_nxt   = 2'd3;
        fsm_nxt = ST_TK_HM;
      end
      ST_TK_HM: begin
        mul_a   = {1'b0, t2_r};
        mul_b   = r_r;
        fsm_nxt = ST_TK_HA;
      end
      ST_TK_HA: begin
        r_nxt = SIN_COEF[k_r] - mul_p[61:30];
        if (k_r == 2'd0) begin
          fsm_nxt = ST_TK_S;
        end else begin
          k_nxt   = k_r - 2'd1;
          fsm_nxt = ST_TK_HM;
        end
      end
      ST_TK_S: begin
        mul_a   = {1'b0, t_r};
        mul_b   = r_r;
        fsm_nxt = ST_TK_MAG;
      end
      ST_TK_MAG: begin
        mag_nxt = sat15(sine_m[46:30]);
        fsm_nxt = ST_TK_AMP;
      end
      ST_TK_AMP: begin
        mul_a   = {17'b0, mag_r};
        mul_b   = {16'b0, st_r.amp};
        fsm_nxt = ST_TK_P;
      end
      ST_TK_P: begin
        if (st_r.tail != '0) begin
          mul_a   = {1'b0, mul_p[30:0]};
          mul_b   = {15'b0, st_r.tail};
          fsm_nxt = ST_TK_TL;
        end else begin
          gain_m   = mul_p[32:16];
          mag16    = {1'b0, sat15(gain_m)};
          samp_nxt = neg_r ? $signed(16'd0 - mag16) : $signed(mag16);
          fsm_nxt  = ST_EMIT;
        end
      end
      ST_TK_TL: begin
        gain_m   = mul_p[48:32];
        mag16    = {1'b0, sat15(gain_m)};
        samp_nxt = neg_r ? $signed(16'd0 - mag16) : $signed(mag16);
        mul_a    = {15'b0, st_r.tail};
        mul_b    = {16'b0, TAIL_DECAY};
        fsm_nxt  = ST_TK_DEC;
      end
      ST_TK_DEC: begin
        // drop the voice once the tail has decayed to the floor
        if (tail_dec <= TAIL_STOP) begin
          st_nxt.step = '0;
          st_nxt.tail = '0;
        end else begin
          st_nxt.tail = tail_dec;
        end
        fsm_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          mem_wr_en  = 1'b1;
          mem_ok_nxt = 1'b1;
          fsm_nxt    = ST_IDLE;
        end
      end
      ST_WB: begin
        mem_wr_en  = 1'b1;
        mem_ok_nxt = 1'b1;
        fsm_nxt    = ST_IDLE;
      end
      default: fsm_nxt = ST_IDLE;
    endcase
  end

  assign mem_wr_data = st_r;
  assign res.sample  = samp_r;
  assign res.active  = (st_r.step != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r    <= ST_IDLE;
      mem_ok_r <= 1'b0;
    end else begin
      fsm_r    <= fsm_nxt;
      mem_ok_r <= mem_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    note_r <= note_nxt;
    vel_r  <= vel_nxt;
    st_r   <= st_nxt;
    t_r    <= t_nxt;
    t2_r   <= t2_nxt;
    r_r    <= r_nxt;
    k_r    <= k_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    samp_r <= samp_nxt;
  end

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (fsm_r == ST_EMIT || fsm_r == ST_WB))
    else $error("state write outside write-back");

  a_wr_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |=> (mem_ok_r && fsm_r == ST_IDLE))
    else $error("write-back did not return to idle with valid word");

  a_horner_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == ST_TK_S) |-> (k_r == 2'd0))
    else $error("polynomial left before last coefficient");

  a_res_tick: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (req_r == REQ_TICK && !req_ready))
    else $error("result for a non-tick request");

endmodule

// ----- hdl/sine_voice_with_release_decay_unit.sv -----
// Top level of the sine voice: config register, voice-state memory, shared
// multiplier, sequencer and output register. Depends on vsr_pkg and all hdl/ modules.
//
//  channel  | ports                        | payload (low bit up)
//  ---------+------------------------------+-----------------------------------------
//  input    | in_tvalid/in_tready          | in_tuser: req_type[1:0]
//           |                              | in_tdata: note_number[6:0], note_velocity[13:7]
//  result   | out_tvalid/out_tready        | out_tdata: sample_value[15:0], voice_active[16]
//  config   | cfg_wr_en, cfg_wr_data       | hz_to_phase_scale[35:0]
//
// Flow: one word at a time. A sample tick on a sounding voice runs the Horner steps of
// the sine polynomial on the single shared multiplier, then the tail product and decay
// step if a release is running, before out_tvalid rises; the next word is taken once
// the sequencer is back in idle. Note-on runs the amplitude and both step products
// through the multiplier; release, stop and a tick on an idle voice do not use it.
// Reset: synchronous, active low; the voice word reads as zero until first written
// (one valid flop), the scale returns to its 48 kHz value. No clearing pass.
// Stalls: a finished sample waits in the output register; the next input word is
// taken meanwhile, and a second sample holds in the sequencer until the register frees.
module sine_voice_with_release_decay_unit
  import vsr_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // note_number[6:0], note_velocity[13:7], zero fill
  input  logic [1:0]   in_tuser,   // req_type[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // sample_value[15:0], voice_active[16], zero fill
  input  logic         cfg_wr_en,
  input  logic [35:0]  cfg_wr_data // hz_to_phase_scale
);

  localparam int STATE_W = $bits(vsr_state_t);

  logic [SCALE_W-1:0] scale_r;

  vsr_state_t  mem_rd_data;
  vsr_state_t  mem_wr_data;
  logic        mem_wr_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic        res_valid;
  logic        res_ready;
  vsr_res_t    res;

  logic        out_valid_r;
  vsr_res_t    out_res_r;

  // hold the scale; the user must write it only while the voice is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  // single voice word, read every cycle at the only address
  vsr_ram #(
    .WIDTH (STATE_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (1'b0),
    .wr_data (mem_wr_data),
    .rd_addr (1'b0),
    .rd_data (mem_rd_data)
  );

  vsr_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  vsr_core #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (in_tvalid),
    .req_ready     (in_tready),
    .req_type      (vsr_req_t'(in_tuser)),
    .note_number   (in_tdata[6:0]),
    .note_velocity (in_tdata[13:7]),
    .scale         (scale_r),
    .mem_rd_data   (mem_rd_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_data   (mem_wr_data),
    .mul_a         (mul_a),
    .mul_b         (mul_b),
    .mul_p         (mul_p),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.active, out_res_r.sample};

endmodule
